[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the 3x3 median filter.
// No dependencies; define SYNTH to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");
// The condition must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

[rtl/mf3_pkg.sv]
// Constants, types and compare helpers for the 3x3 median filter.
// No dependencies; used by the stream interfaces and the top level.
package mf3_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int PIX_W      = 8;
  localparam int CFG_W      = 12;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 12;
  localparam int WIN        = 3;
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef logic [CFG_W-1:0] cfg_t;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam cfg_t WIDTH_RESET  = 12'd640;
  localparam cfg_t HEIGHT_RESET = 12'd480;

  typedef struct packed {
    pixel_t lo;
    pixel_t md;
    pixel_t hi;
  } triple_t;

  function automatic pixel_t min2(pixel_t a, pixel_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pixel_t max2(pixel_t a, pixel_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pixel_t min3(pixel_t a, pixel_t b, pixel_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pixel_t max3(pixel_t a, pixel_t b, pixel_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pixel_t med3(pixel_t a, pixel_t b, pixel_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic triple_t sort3(pixel_t a, pixel_t b, pixel_t c);
    triple_t r;
    r.lo = min3(a, b, c);
    r.md = med3(a, b, c);
    r.hi = max3(a, b, c);
    return r;
  endfunction

  // Last column index of a row: zero means one pixel, wide rows saturate.
  function automatic col_t width_m1(cfg_t v);
    int w;
    w = int'(v);
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return col_t'(w - 1);
  endfunction

  // Last row index of a frame: zero means one row.
  function automatic row_t height_m1(cfg_t v);
    return (v == '0) ? '0 : row_t'(v - cfg_t'(1));
  endfunction

endpackage

[rtl/mf3_pix_in_if.sv]
// Input stream channel of the median filter: valid/ready with an opcode and a pixel.
// Depends on mf3_pkg.
interface mf3_pix_in_if import mf3_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   opcode;
  pixel_t pixel_in;

  modport source (output valid, output opcode, output pixel_in, input ready);
  modport sink   (input valid, input opcode, input pixel_in, output ready);
endinterface

[rtl/mf3_pix_out_if.sv]
// Output stream channel of the median filter: valid/ready with a pixel and frame end.
// Depends on mf3_pkg.
interface mf3_pix_out_if import mf3_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t pixel_out;
  logic   frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

[rtl/median_filter_3x3.sv]
// Streaming 3x3 median filter for 8-bit grey frames, top level.
// Depends on mf3_pkg, mf3_pix_in_if, mf3_pix_out_if and assert_macros.svh.
//
// Usage: pixels arrive on the pixels channel in raster order; opcode selects a
// pixel transaction or a drain transaction. Filtered pixels leave on the results
// channel in raster order, trailing the input by image_width + 1 transactions;
// after the last pixel of a frame, send drain transactions to flush the rest.
// frame_end marks the last output pixel of a frame. Interior pixels get the
// median of their 3x3 neighborhood, border pixels pass through.
// Throughput is one transaction per cycle while pixels.ready is high. Two line
// memories (one read and one write port each) hold the previous rows; a column
// is read and later written back, and forwarding registers cover back-to-back hits.
// A result reaches results through the line memory read at the edge that accepts
// its transaction, the window update, the median tree and the output FIFO.
// Results collect in an 8-entry output FIFO; pixels.ready drops while eight
// results are outstanding, so a stalled receiver stops the input after that.
// Configuration writes (cfg_we, cfg_index, cfg_data) abort the current frame.
// Reset sets width 640 and height 480 and clears all position counters; the
// line memories keep their contents and need no clearing pass.
`include "assert_macros.svh"

module median_filter_3x3 import mf3_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  mf3_pix_in_if.sink     pixels,
  mf3_pix_out_if.source  results,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  cfg_t           cfg_data
);

  typedef struct packed {
    logic emit;
    logic median;
    logic last;
  } stage_ctrl_t;

  typedef struct packed {
    pixel_t pixel;
    logic   frame_end;
  } out_item_t;

  // Frame geometry, held as last column and last row index.
  col_t wm1;
  row_t hm1;

  // Position counters.
  col_t in_column, in_column_next, out_column, out_column_next;
  row_t in_row, in_row_next, out_row, out_row_next;
  logic draining, draining_next;

  logic accept, pixel_live, drain_live, has_out, emit_a, out_last, out_interior;
  col_t rd_addr;

  // Line memories.
  pixel_t upper_mem [MAX_WIDTH];
  pixel_t middle_mem [MAX_WIDTH];
  pixel_t upper_rd, middle_rd;

  // Read data stage: write back, window update.
  logic   b_we, b_emit, b_drain, b_median, b_last, b_sel_middle;
  col_t   b_addr;
  pixel_t b_pix;
  logic   fwd;
  pixel_t fwd_upper, fwd_middle, up_eff, mid_eff;
  pixel_t win [WIN][WIN];

  // Median stages.
  stage_ctrl_t c_ctrl, d_ctrl, e_ctrl;
  logic        c_drain;
  pixel_t      c_val, d_val, e_val;
  triple_t     d_col [WIN];
  pixel_t      e_lo, e_md, e_hi;

  // Output FIFO and credit.
  out_item_t          fifo [FIFO_DEPTH];
  out_item_t          push_item;
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   fifo_count, credit;
  logic               push, pop;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      wm1 <= width_m1(WIDTH_RESET);
      hm1 <= height_m1(HEIGHT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  wm1 <= width_m1(cfg_data);
        REG_IMAGE_HEIGHT: hm1 <= height_m1(cfg_data);
      endcase
    end
  end

  // ---------------------------------------------------------------- accept
  assign pixels.ready = credit < CNT_W'(FIFO_DEPTH);
  assign accept       = pixels.valid && pixels.ready;
  assign pixel_live   = accept && (pixels.opcode == OP_PIXEL) && !draining;
  assign drain_live   = accept && (pixels.opcode == OP_DRAIN) && draining;

  // An output exists once one row plus one pixel has gone in.
  assign has_out = (in_row >= ROW_W'(2)) || (in_row == ROW_W'(1) && in_column != '0);
  assign emit_a  = drain_live || (pixel_live && has_out);

  assign out_last     = (out_row == hm1) && (out_column == wm1);
  assign out_interior = (out_row != '0) && (out_row < hm1) &&
                        (out_column != '0) && (out_column < wm1);

  // Pixels read their own column, drains read the column being output.
  assign rd_addr = draining ? out_column : in_column;

  always_comb begin
    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    draining_next   = draining;
    if (cfg_we) begin
      in_column_next  = '0;
      in_row_next     = '0;
      out_column_next = '0;
      out_row_next    = '0;
      draining_next   = 1'b0;
    end else begin
      if (emit_a) begin
        priority if (out_last) begin
          out_column_next = '0;
          out_row_next    = '0;
        end else if (out_column == wm1) begin
          out_column_next = '0;
          out_row_next    = out_row + ROW_W'(1);
        end else begin
          out_column_next = out_column + COL_W'(1);
        end
      end
      if (pixel_live) begin
        priority if (in_row == hm1 && in_column == wm1) begin
          in_column_next = '0;
          in_row_next    = '0;
          draining_next  = 1'b1;
        end else if (in_column == wm1) begin
          in_column_next = '0;
          in_row_next    = in_row + ROW_W'(1);
        end else begin
          in_column_next = in_column + COL_W'(1);
        end
      end
      if (drain_live && out_last) begin
        draining_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      draining   <= 1'b0;
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
      draining   <= draining_next;
    end
  end

  // ---------------------------------------------------------------- line memories
  always_ff @(posedge clk) begin
    if (b_we) begin
      upper_mem[b_addr]  <= mid_eff;
      middle_mem[b_addr] <= b_pix;
    end
    upper_rd  <= upper_mem[rd_addr];
    middle_rd <= middle_mem[rd_addr];
  end

  // A read at the column being written in the same cycle sees old data, so the
  // written values are captured and used in place of the read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= (pixel_live || drain_live) && b_we && (rd_addr == b_addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_upper  <= mid_eff;
    fwd_middle <= b_pix;
  end

  assign up_eff  = fwd ? fwd_upper  : upper_rd;
  assign mid_eff = fwd ? fwd_middle : middle_rd;

  // ---------------------------------------------------------------- read data stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_we   <= 1'b0;
      b_emit <= 1'b0;
    end else begin
      b_we   <= pixel_live;
      b_emit <= emit_a;
    end
  end

  always_ff @(posedge clk) begin
    b_addr       <= rd_addr;
    b_pix        <= pixels.pixel_in;
    b_drain      <= drain_live;
    b_median     <= pixel_live && out_interior;
    b_last       <= out_last;
    b_sel_middle <= (out_row == hm1);
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      for (int r = 0; r < WIN; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= up_eff;
      win[1][2] <= mid_eff;
      win[2][2] <= b_pix;
    end
  end

  // ---------------------------------------------------------------- median stages
  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctrl <= '0;
      d_ctrl <= '0;
      e_ctrl <= '0;
    end else begin
      c_ctrl <= '{emit: b_emit, median: b_median, last: b_last};
      d_ctrl <= c_ctrl;
      e_ctrl <= d_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    c_drain <= b_drain;
    c_val   <= b_sel_middle ? mid_eff : up_eff;
    // The window center is the output position of a pixel transaction.
    d_val   <= c_drain ? c_val : win[1][1];
    for (int k = 0; k < WIN; k++) begin
      d_col[k] <= sort3(win[0][k], win[1][k], win[2][k]);
    end
    e_lo  <= max3(d_col[0].lo, d_col[1].lo, d_col[2].lo);
    e_md  <= med3(d_col[0].md, d_col[1].md, d_col[2].md);
    e_hi  <= min3(d_col[0].hi, d_col[1].hi, d_col[2].hi);
    e_val <= d_val;
  end

  // ---------------------------------------------------------------- output FIFO
  assign push                = e_ctrl.emit;
  assign push_item.pixel     = e_ctrl.median ? med3(e_lo, e_md, e_hi) : e_val;
  assign push_item.frame_end = e_ctrl.last;
  assign pop                 = results.valid && results.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
      credit     <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      fifo_count <= fifo_count + CNT_W'(push) - CNT_W'(pop);
      credit     <= credit + CNT_W'(emit_a) - CNT_W'(pop);
    end
  end

  assign results.valid     = (fifo_count != '0);
  assign results.pixel_out = fifo[rd_ptr].pixel;
  assign results.frame_end = fifo[rd_ptr].frame_end;

  // ---------------------------------------------------------------- checks
  `ASSERT_NEVER(a_fifo_overflow, clk, rst, push && !pop && fifo_count == CNT_W'(FIFO_DEPTH))
  `ASSERT_IMPLIES(a_credit_covers_fifo, clk, rst, 1'b1, fifo_count <= credit)
  `ASSERT_IMPLIES(a_fwd_after_write, clk, rst, fwd, $past(b_we))
  `ASSERT_IMPLIES(a_last_is_border, clk, rst, push && e_ctrl.last, !e_ctrl.median)
  `ASSERT_IMPLIES(a_drain_input_idle, clk, rst, draining, in_column == '0 && in_row == '0)

endmodule

[tb/sv/testbench.sv]
// Testbench for the streaming 3x3 median filter: random and directed frames with
// a cycle-free predictor that checks every filtered pixel and its frame_end flag.
// Depends on mf3_pkg, mf3_pix_in_if, mf3_pix_out_if and median_filter_3x3.
`timescale 1ns / 100ps

module testbench;
  import mf3_pkg::*;

  localparam int ITEM_GOAL   = 1350;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYC  = 12;
  localparam int MAX_REPORTS = 200;

  typedef struct {
    pixel_t pix;
    logic   last;
  } out_pixel_t;

  // Tracks the frame position, line stores and window of the filter and keeps
  // the filtered pixels that are due on the output channel, oldest first.
  class median_tracker;
    cfg_t       width_reg;
    cfg_t       height_reg;
    pixel_t     upper_line[MAX_WIDTH];
    pixel_t     middle_line[MAX_WIDTH];
    pixel_t     win[WIN*WIN];
    col_t       in_col;
    col_t       out_col;
    row_t       in_row;
    row_t       out_row;
    bit         draining;
    out_pixel_t due_pixels[$];
    int         failures;

    function new();
      failures = 0;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (win[i]) win[i] = '0;
      foreach (upper_line[i]) upper_line[i] = '0;
      foreach (middle_line[i]) middle_line[i] = '0;
      restart();
    endfunction

    function void restart();
      in_col = '0;
      in_row = '0;
      out_col = '0;
      out_row = '0;
      draining = 1'b0;
    endfunction

    function int cols();
      int w;
      w = int'(width_reg);
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
    endfunction

    function int rows();
      return (height_reg == '0) ? 1 : int'(height_reg);
    endfunction

    function int frame_size();
      return cols() * rows();
    endfunction

    function int outstanding();
      return due_pixels.size();
    endfunction

    // A register write takes effect at once and abandons the frame in flight.
    function void set_reg(logic idx, cfg_t val);
      if (idx == REG_IMAGE_WIDTH) width_reg = val;
      else height_reg = val;
      restart();
    endfunction

    // Fifth smallest of nine: the value with at most four below it and at
    // least five at or below it.
    function pixel_t window_median();
      int below;
      int upto;
      for (int i = 0; i < WIN*WIN; i++) begin
        below = 0;
        upto = 0;
        for (int j = 0; j < WIN*WIN; j++) begin
          if (win[j] < win[i]) below++;
          if (win[j] <= win[i]) upto++;
        end
        if (below <= 4 && upto >= 5) return win[i];
      end
      return win[4];
    endfunction

    function void emit(pixel_t v);
      out_pixel_t e;
      bit last;
      last = (int'(out_row) == rows() - 1) && (int'(out_col) == cols() - 1);
      e.pix = v;
      e.last = last;
      due_pixels.push_back(e);
      if (last) begin
        restart();
      end else if (int'(out_col) == cols() - 1) begin
        out_col = '0;
        out_row++;
      end else begin
        out_col++;
      end
    endfunction

    function void note_input(logic op, pixel_t pix);
      int w;
      int h;
      pixel_t up;
      pixel_t mid;
      bit has_out;
      bit interior;
      w = cols();
      h = rows();
      if (op == OP_DRAIN) begin
        if (!draining) return;
        emit((int'(out_row) == h - 1) ? middle_line[out_col] : upper_line[out_col]);
        return;
      end
      if (draining) return;
      up = upper_line[in_col];
      mid = middle_line[in_col];
      has_out = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      for (int k = 0; k < WIN; k++) begin
        win[k*WIN]     = win[k*WIN + 1];
        win[k*WIN + 1] = win[k*WIN + 2];
      end
      win[2] = up;
      win[5] = mid;
      win[8] = pix;
      if (has_out) begin
        interior = out_row >= 1 && int'(out_row) + 2 <= h &&
                   out_col >= 1 && int'(out_col) + 2 <= w;
        emit(interior ? window_median() : upper_line[out_col]);
      end
      upper_line[in_col] = mid;
      middle_line[in_col] = pix;
      if (int'(in_row) == h - 1 && int'(in_col) == w - 1) begin
        draining = 1'b1;
        in_col = '0;
        in_row = '0;
      end else if (int'(in_col) == w - 1) begin
        in_col = '0;
        in_row++;
      end else begin
        in_col++;
      end
    endfunction

    function void check_result(pixel_t pix, logic fe);
      out_pixel_t e;
      if (due_pixels.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: unexpected output pixel %0d frame_end %0b", $time, pix, fe);
        return;
      end
      e = due_pixels.pop_front();
      if (pix !== e.pix) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: pixel_out expected %0d, got %0d", $time, e.pix, pix);
      end
      if (fe !== e.last) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: frame_end expected %0b, got %0b", $time, e.last, fe);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic cfg_index;
  cfg_t cfg_data;

  mf3_pix_in_if  pix_ch ();
  mf3_pix_out_if res_ch ();

  median_filter_3x3 uut (
    .clk      (clk),
    .rst      (rst),
    .pixels   (pix_ch),
    .results  (res_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  median_tracker tracker;
  int src_idle_pct = 24;
  int snk_idle_pct = 46;
  int items = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready)
      tracker.check_result(res_ch.pixel_out, res_ch.frame_end);
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (pix_ch.valid && pix_ch.ready) ||
        (res_ch.valid === 1'b1 && res_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offers one transaction, with random idle cycles first, and returns at the
  // edge that accepts it. valid is left high; the idle cycles of the next call or a pause lower it.
  task automatic send_item(input logic op, input pixel_t pix);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.opcode <= op;
    pix_ch.pixel_in <= pix;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    tracker.note_input(op, pix);
  endtask

  task automatic hold_until_empty();
    @(negedge clk);
    pix_ch.valid <= 1'b0;
    while (tracker.outstanding() > 0) @(negedge clk);
  endtask

  // Transactions that produce no result still pass through the pipeline, so give it time to empty as well.
  task automatic settle();
    hold_until_empty();
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input cfg_t val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    tracker.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic pixel_t pick_pixel();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    // A narrow band gives windows full of equal values.
    if (r < 4) return pixel_t'($urandom_range(103, 100));
    return pixel_t'($urandom_range(255));
  endfunction

  // Sends stop_at pixels of the current frame; a complete frame is then drained.
  task automatic play_frame(input int stop_at);
    for (int i = 0; i < stop_at; i++) begin
      if ($urandom_range(49) == 0) send_item(OP_DRAIN, pick_pixel());
      if ($urandom_range(299) == 0) hold_until_empty();
      send_item(OP_PIXEL, pick_pixel());
      items++;
    end
    while (tracker.draining) begin
      if ($urandom_range(15) == 0) send_item(OP_PIXEL, pick_pixel());
      send_item(OP_DRAIN, pick_pixel());
      items++;
    end
  endtask

  function automatic cfg_t pick_size(input int hi);
    int r;
    r = $urandom_range(9);
    if (r < 3) return cfg_t'(r);
    return cfg_t'($urandom_range(hi, 3));
  endfunction

  initial begin
    int total;
    int nframes;
    int sel;
    bit aborted;
    cfg_we = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data = '0;
    pix_ch.valid = 1'b0;
    pix_ch.opcode = OP_PIXEL;
    pix_ch.pixel_in = '0;
    res_ch.ready = 1'b0;
    tracker = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset geometry: part of a 640-wide frame, then abandoned.
    play_frame(660);
    settle();

    // Directed 3x3 frame with extreme pixels and both kinds of ignored transaction.
    write_reg(REG_IMAGE_WIDTH, 12'd3);
    write_reg(REG_IMAGE_HEIGHT, 12'd3);
    send_item(OP_DRAIN, 8'd255);
    send_item(OP_PIXEL, 8'd0);
    send_item(OP_PIXEL, 8'd255);
    send_item(OP_PIXEL, 8'd0);
    send_item(OP_PIXEL, 8'd255);
    send_item(OP_PIXEL, 8'd128);
    send_item(OP_PIXEL, 8'd1);
    send_item(OP_PIXEL, 8'd2);
    send_item(OP_PIXEL, 8'd254);
    send_item(OP_PIXEL, 8'd127);
    send_item(OP_DRAIN, 8'd0);
    send_item(OP_PIXEL, 8'd85);
    send_item(OP_DRAIN, 8'd170);
    send_item(OP_DRAIN, 8'd0);
    send_item(OP_DRAIN, 8'd255);
    settle();

    // Narrow frame at the largest height, abandoned after twenty rows.
    write_reg(REG_IMAGE_HEIGHT, 12'd4095);
    play_frame(60);

    while (items < ITEM_GOAL) begin
      if (items < ITEM_GOAL / 3) begin
        src_idle_pct = 24;
        snk_idle_pct = 46;
      end else if (items < 2 * ITEM_GOAL / 3) begin
        src_idle_pct = 46;
        snk_idle_pct = 24;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      settle();
      sel = $urandom_range(2);
      if (sel != 2) write_reg(REG_IMAGE_WIDTH, pick_size(14));
      if (sel != 1) write_reg(REG_IMAGE_HEIGHT, pick_size(9));
      nframes = $urandom_range(3, 1);
      aborted = 1'b0;
      for (int f = 0; f < nframes && !aborted; f++) begin
        total = tracker.frame_size();
        // An abandoned frame ends the phase; the next register write aborts it.
        if (total > 1 && $urandom_range(7) == 0) begin
          play_frame($urandom_range(total - 1, 1));
          aborted = 1'b1;
        end else begin
          play_frame(total);
        end
      end
    end

    hold_until_empty();
    repeat (20) @(negedge clk);
    if (tracker.failures == 0 && tracker.outstanding() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
